/* hdl/linear_rpm_ramp_setpoint_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the speed setpoint ramp
// ---------------------------------------------------------------------------
`ifndef LINEAR_RPM_RAMP_SETPOINT_TOP_ASSERT_SVH
`define LINEAR_RPM_RAMP_SETPOINT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LRR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define LRR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define LRR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define LRR_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/lrr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrr_pkg
// Types and constants shared by the speed setpoint ramp modules.
// ---------------------------------------------------------------------------
package lrr_pkg;

   localparam int SPEED_BITS = 20;
   localparam int STEP_BITS  = 16;
   localparam int TIME_BITS  = 24;
   localparam int TICK_BITS  = 32;
   localparam int THR_BITS   = 8;

   localparam int PROD_W     = SPEED_BITS + STEP_BITS;
   localparam int DIV_W      = (PROD_W > TIME_BITS) ? PROD_W : TIME_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_W);

   localparam logic [1:0] REQ_UPDATE = 2'd0;
   localparam logic [1:0] REQ_UP     = 2'd1;
   localparam logic [1:0] REQ_DOWN   = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_UP   = 2'd1,
      MODE_DOWN = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_RESULT
   } ctrl_state_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [TICK_BITS-1:0]  now_ms;
      logic [SPEED_BITS-1:0] goal_rpm;
      logic [STEP_BITS-1:0]  steps;
      logic [TIME_BITS-1:0]  span_ms;
      logic [SPEED_BITS-1:0] measured_rpm;
   } req_item_type;

   typedef struct packed {
      logic [SPEED_BITS-1:0] setpoint_rpm;
      logic                  motor_off;
      logic [1:0]            ramp_mode;
      logic                  ramp_finished;
      logic                  command_accepted;
   } rsp_item_type;

   typedef struct packed {
      logic load_req;
      logic load_diff;
      logic load_prod;
      logic div_start;
      logic apply;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic is_update;
      logic step_due;
      logic cmd_ok;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

/* hdl/lrr_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrr_div
// Serial restoring divider, one quotient bit per cycle. The divisor must be
// non-zero; done pulses for one cycle once the quotient is valid.
// ---------------------------------------------------------------------------
module lrr_div
   import lrr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [STEP_BITS-1:0] divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          quotient
);

   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [STEP_BITS-1:0] rem_ff, rem_in;
   logic [STEP_BITS-1:0] dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = DIV_CNT_W'(DIV_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         // shift in the next dividend bit, quotient bit enters at the bottom
         dvd_in = {dvd_ff[DIV_W-2:0], fits};
         rem_in = fits ? STEP_BITS'(trial - {1'b0, dsr_ff}) : trial[STEP_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule
`default_nettype wire

/* hdl/lrr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrr_dp
// Ramp datapath: ramp state, threshold register, multiplier, shared
// divider and the result register.
// ---------------------------------------------------------------------------
module lrr_dp
   import lrr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   output dp_status_type            status,
   input  wire req_item_type        req_data,
   input  wire logic                csr_valid,
   input  wire logic                csr_ready,
   input  wire logic [THR_BITS-1:0] csr_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_item_type             rsp_data
);

   req_item_type          req_ff;
   logic [THR_BITS-1:0]   thr_ff;
   mode_type              mode_ff, mode_in;
   logic [SPEED_BITS-1:0] start_ff, start_in;
   logic [SPEED_BITS-1:0] goal_ff, goal_in;
   logic [SPEED_BITS-1:0] prof_ff, prof_in;
   logic [STEP_BITS-1:0]  total_ff, total_in;
   logic [TIME_BITS-1:0]  intv_ff, intv_in;
   logic [TICK_BITS-1:0]  last_ff, last_in;
   logic [STEP_BITS-1:0]  done_ff, done_in;
   logic                  fin_ff, fin_in;
   logic                  acc_ff, acc_in;
   logic [SPEED_BITS-1:0] diff_ff;
   logic [PROD_W-1:0]     prod_ff;
   rsp_item_type          rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  is_update;
   logic                  up_dir;
   logic [SPEED_BITS-1:0] diff_in;
   logic [SPEED_BITS-1:0] thr_ext;
   logic [TICK_BITS-1:0]  elapsed;
   logic [DIV_W-1:0]      div_dividend;
   logic [STEP_BITS-1:0]  div_divisor;
   logic                  div_done;
   logic [DIV_W-1:0]      quot;
   logic [SPEED_BITS-1:0] offset;
   logic [SPEED_BITS-1:0] step_prof;
   logic [STEP_BITS-1:0]  done_next;
   logic [SPEED_BITS-1:0] setpoint;
   logic                  sp_off;

   assign is_update = req_ff.req_type == REQ_UPDATE;
   assign up_dir    = goal_ff >= start_ff;
   assign diff_in   = up_dir ? goal_ff - start_ff : start_ff - goal_ff;
   assign thr_ext   = SPEED_BITS'(thr_ff);
   assign elapsed   = req_ff.now_ms - last_ff;

   assign status.is_update = is_update;
   assign status.step_due  = (mode_ff != MODE_IDLE) &&
                             (elapsed >= TICK_BITS'(intv_ff));
   assign status.cmd_ok    = (((req_ff.req_type == REQ_UP) && (mode_ff == MODE_IDLE)) ||
                              ((req_ff.req_type == REQ_DOWN) && (mode_ff != MODE_DOWN))) &&
                             (req_ff.steps != '0) && (req_ff.span_ms != '0);
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign div_dividend = is_update ? DIV_W'(prod_ff) : DIV_W'(req_ff.span_ms);
   assign div_divisor  = is_update ? total_ff : req_ff.steps;

   lrr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   // profile step: offset from start, clamped toward the goal
   always_comb begin
      offset    = (quot > DIV_W'(diff_ff)) ? diff_ff : quot[SPEED_BITS-1:0];
      step_prof = up_dir ? start_ff + offset : start_ff - offset;
      if ((mode_ff == MODE_UP) && (step_prof > goal_ff)) begin
         step_prof = goal_ff;
      end
      if ((mode_ff == MODE_DOWN) && (step_prof < goal_ff)) begin
         step_prof = goal_ff;
      end
      done_next = done_ff + 1'b1;
   end

   always_comb begin
      if (mode_ff != MODE_IDLE) begin
         setpoint = prof_ff;
      end else if (is_update) begin
         setpoint = req_ff.goal_rpm;
      end else begin
         setpoint = goal_ff;
      end
      sp_off = setpoint <= thr_ext;
   end

   always_comb begin
      mode_in      = mode_ff;
      start_in     = start_ff;
      goal_in      = goal_ff;
      prof_in      = prof_ff;
      total_in     = total_ff;
      intv_in      = intv_ff;
      last_in      = last_ff;
      done_in      = done_ff;
      fin_in       = fin_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_req) begin
         fin_in = 1'b0;
         acc_in = 1'b0;
      end
      if (cmd.apply) begin
         last_in = req_ff.now_ms;
         if (is_update) begin
            done_in = done_next;
            prof_in = step_prof;
            if (done_next >= total_ff) begin
               prof_in = ((mode_ff == MODE_DOWN) && (goal_ff <= thr_ext)) ? '0 : goal_ff;
               mode_in = MODE_IDLE;
               fin_in  = 1'b1;
            end
         end else begin
            mode_in  = (req_ff.req_type == REQ_UP) ? MODE_UP : MODE_DOWN;
            goal_in  = req_ff.goal_rpm;
            start_in = req_ff.measured_rpm;
            prof_in  = req_ff.measured_rpm;
            total_in = req_ff.steps;
            intv_in  = quot[TIME_BITS-1:0];
            done_in  = '0;
            acc_in   = 1'b1;
         end
      end
      if (cmd.emit) begin
         rsp_in.setpoint_rpm     = setpoint;
         rsp_in.motor_off        = sp_off;
         rsp_in.ramp_mode        = mode_ff;
         rsp_in.ramp_finished    = fin_ff;
         rsp_in.command_accepted = acc_ff;
         rsp_valid_in            = 1'b1;
         if (is_update) begin
            if (mode_ff == MODE_IDLE) begin
               goal_in = req_ff.goal_rpm;
            end
            if (sp_off) begin
               prof_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= THR_BITS'(1);
         mode_ff      <= MODE_IDLE;
         start_ff     <= '0;
         goal_ff      <= '0;
         prof_ff      <= '0;
         total_ff     <= '0;
         intv_ff      <= '0;
         last_ff      <= '0;
         done_ff      <= '0;
         fin_ff       <= 1'b0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_data;
         end
         mode_ff      <= mode_in;
         start_ff     <= start_in;
         goal_ff      <= goal_in;
         prof_ff      <= prof_in;
         total_ff     <= total_in;
         intv_ff      <= intv_in;
         last_ff      <= last_in;
         done_ff      <= done_in;
         fin_ff       <= fin_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.load_prod) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'(done_ff);
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

/* hdl/lrr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lrr_ctrl
// Sequencer for the ramp: takes a request, decides between step, command
// and pass-through, runs the divider and releases the result.
// ---------------------------------------------------------------------------
module lrr_ctrl
   import lrr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_update) begin
               if (status.step_due) begin
                  cmd.load_diff = 1'b1;
                  state_in      = ST_MUL;
               end else begin
                  state_in = ST_RESULT;
               end
            end else if (status.cmd_ok) begin
               state_in = ST_DIV_GO;
            end else begin
               // rejected command: state untouched
               state_in = ST_RESULT;
            end
         end
         ST_MUL: begin
            cmd.load_prod = 1'b1;
            state_in      = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.apply = 1'b1;
               state_in  = ST_RESULT;
            end
         end
         ST_RESULT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* hdl/linear_rpm_ramp_setpoint_top.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "linear_rpm_ramp_setpoint_top_assert.svh"
// ---------------------------------------------------------------------------
// linear_rpm_ramp_setpoint_top
// Linear speed setpoint ramp for a spindle motor, one result per request.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_item_type
//   rsp      out        rsp_valid/rsp_ready    rsp_item_type
//   csr      in         csr_valid/csr_ready    off threshold, 8 bits
//
// One request at a time. A step-taking update and an accepted command
// run the serial divider, one quotient bit a cycle over 36 bits; other
// requests do not use it.
// A new request is taken while the previous result waits in the output
// register; a stalled result holds the sequencer before its own release.
// Synchronous reset clears the ramp state and sets the off threshold to 1.
// ---------------------------------------------------------------------------
module linear_rpm_ramp_setpoint_top
   import lrr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire req_item_type        req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rsp_item_type             rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [THR_BITS-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   lrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lrr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `LRR_ASSERT_NXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")
   `LRR_ASSERT_IMP(a_accept_mode, clock, reset, rsp_valid && rsp_data.command_accepted, rsp_data.ramp_mode != MODE_IDLE, "accepted command left block idle")
   `LRR_ASSERT_IMP(a_finish_idle, clock, reset, rsp_valid && rsp_data.ramp_finished, rsp_data.ramp_mode == MODE_IDLE, "finished ramp not idle")
   `LRR_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, !rsp_valid || rsp_ready, "result overwritten")

endmodule
`default_nettype wire
